[hw/rtl/stam_pkg.sv]
`default_nettype none
package stam_pkg;

  localparam int NUM_CODES   = 6;
  localparam int MAX_RESULTS = 16;

  // alert codes
  localparam logic [2:0] CODE_TEMP_LOW  = 3'd0;
  localparam logic [2:0] CODE_TEMP_HIGH = 3'd1;
  localparam logic [2:0] CODE_HUM_HIGH  = 3'd2;
  localparam logic [2:0] CODE_RISING    = 3'd3;
  localparam logic [2:0] CODE_FALLING   = 3'd4;
  localparam logic [2:0] CODE_OFFLINE   = 3'd5;

  // register indexes
  localparam logic [2:0] REG_TEMP_LOW  = 3'd0;
  localparam logic [2:0] REG_TEMP_HIGH = 3'd1;
  localparam logic [2:0] REG_HUM_HIGH  = 3'd2;
  localparam logic [2:0] REG_RATE      = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;
  localparam logic [2:0] REG_THROTTLE  = 3'd5;

  // register reset values
  localparam logic signed [15:0] RST_TEMP_LOW  = 16'sd288;
  localparam logic signed [15:0] RST_TEMP_HIGH = 16'sd480;
  localparam logic [10:0]        RST_HUM_HIGH  = 11'd1120;
  localparam logic [14:0]        RST_RATE      = 15'd32;
  localparam logic [15:0]        RST_TIMEOUT   = 16'd5;
  localparam logic [15:0]        RST_THROTTLE  = 16'd15;

  localparam int DIV_BITS = 17;

  typedef struct packed {
    logic [3:0]         sensor;
    logic [2:0]         code;
    logic signed [15:0] temperature;
    logic [10:0]        humidity;
    logic signed [15:0] rate;
  } alert_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } thr_req_t;

endpackage
`default_nettype wire

[hw/rtl/stam_if.sv]
`default_nettype none
interface stam_item_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [3:0]         sensor_index;
  logic signed [15:0] temperature;
  logic [10:0]        humidity;
  logic [31:0]        now_minute;
  modport source (output valid, func, sensor_index, temperature, humidity, now_minute,
                  input ready);
  modport sink (input valid, func, sensor_index, temperature, humidity, now_minute,
                output ready);
endinterface

interface stam_alert_if;
  logic               valid;
  logic               ready;
  logic [3:0]         alert_sensor;
  logic [2:0]         alert_code;
  logic signed [15:0] alert_temperature;
  logic [10:0]        alert_humidity;
  logic signed [15:0] alert_rate;
  logic               last_alert;
  modport source (output valid, alert_sensor, alert_code, alert_temperature,
                  alert_humidity, alert_rate, last_alert, input ready);
  modport sink (input valid, alert_sensor, alert_code, alert_temperature,
                alert_humidity, alert_rate, last_alert, output ready);
endinterface

interface stam_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/stam_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module stam_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [stam_pkg::DIV_BITS-1:0] dividend,
  input  wire logic [31:0]                   divisor,
  output logic                               done,
  output logic [stam_pkg::DIV_BITS-1:0]      quotient
);
  localparam int CW = $clog2(stam_pkg::DIV_BITS + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [31:0]   rem;
  logic [31:0]   dvs;
  logic [32:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[stam_pkg::DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CW'(stam_pkg::DIV_BITS);
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quotient <= {quotient[stam_pkg::DIV_BITS-2:0], fits};
      cnt      <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/stam_throttle.sv]
`default_nettype none
// last-alert time per sensor and code; valid bits in flops, times in memory
module stam_throttle #(
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire stam_pkg::thr_req_t       req,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [31:0]              wr_minute,
  output logic                          rd_valid,
  output logic [31:0]                   rd_minute
);
  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vbit;

  always_ff @(posedge clk) begin
    if (req.wr) mem[addr] <= wr_minute;
    if (req.rd) rd_minute <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbit     <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr) vbit[addr] <= 1'b1;
      if (req.rd) rd_valid <= vbit[addr];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sensor_threshold_alert_monitor_core.sv]
`default_nettype none
// channel  dir  handshake       words
// item     in   valid/ready     func, sensor_index, temperature, humidity, now_minute
// alert    out  valid/ready     alert_sensor/code/temperature/humidity/rate, last_alert
// cfg      in   valid/ready     index, data (ready always high)
//
// One item at a time; item.ready is high only when the sequencer is idle.
// A reading goes from idle through S_RD_UPD, then S_DIV while the rate divider runs (17
// quotient bits), then S_PICK for each check with S_TEST for each raised one, then S_FIN.
// A tick scans the sensors in S_PICK, with S_TEST for each offline candidate, then S_FIN.
// Synchronous reset clears the sensor table and throttle valid bits, restores config.
// A stalled alert port holds the sequencer in S_TEST when a second result is ready, and in S_FIN while one is held.
module sensor_threshold_alert_monitor_core #(
  parameter int NUM_SENSORS = 16
) (
  input wire logic    clk,
  input wire logic    rst,
  stam_item_if.sink   item,
  stam_alert_if.source alert,
  stam_cfg_if.sink    cfg
);
  localparam int SW  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int SCW = $clog2(NUM_SENSORS + 1);
  localparam int TD  = NUM_SENSORS * stam_pkg::NUM_CODES;
  localparam int TW  = $clog2(TD);
  localparam int NW  = $clog2(stam_pkg::MAX_RESULTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD_UPD, S_DIV, S_PICK, S_TEST, S_FIN} state_t;

  // configuration
  logic signed [15:0] temp_low, temp_high;
  logic [10:0]        hum_high;
  logic [14:0]        rate_limit;
  logic [15:0]        timeout, window;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_low   <= stam_pkg::RST_TEMP_LOW;
      temp_high  <= stam_pkg::RST_TEMP_HIGH;
      hum_high   <= stam_pkg::RST_HUM_HIGH;
      rate_limit <= stam_pkg::RST_RATE;
      timeout    <= stam_pkg::RST_TIMEOUT;
      window     <= stam_pkg::RST_THROTTLE;
    end else if (cfg.valid) begin
      case (cfg.index)
        stam_pkg::REG_TEMP_LOW:  temp_low   <= cfg.data;
        stam_pkg::REG_TEMP_HIGH: temp_high  <= cfg.data;
        stam_pkg::REG_HUM_HIGH:  hum_high   <= cfg.data[10:0];
        stam_pkg::REG_RATE:      rate_limit <= cfg.data[14:0];
        stam_pkg::REG_TIMEOUT:   timeout    <= cfg.data;
        stam_pkg::REG_THROTTLE:  window     <= cfg.data;
        default: ;
      endcase
    end
  end

  // sensor table
  logic signed [15:0] s_temp [NUM_SENSORS];
  logic [10:0]        s_hum  [NUM_SENSORS];
  logic signed [15:0] s_rate [NUM_SENSORS];
  logic [31:0]        s_upd  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] s_seen, s_active;

  // latched item and sequencer
  state_t             state;
  logic               it_func;
  logic signed [15:0] it_temp;
  logic [10:0]        it_hum;
  logic [31:0]        it_now;
  logic [SCW-1:0]     cur;
  logic [1:0]         step;
  logic [NW-1:0]      cnt;
  logic [2:0]         code;
  logic               neg;

  stam_pkg::alert_t pend;
  logic             pend_valid;

  logic [SW-1:0] curi;
  assign curi = cur[SW-1:0];

  logic item_acc, in_range, out_free;
  assign item.ready = (state == S_IDLE);
  assign item_acc   = item.valid && item.ready;
  assign in_range   = 32'(item.sensor_index) < 32'(NUM_SENSORS);
  assign out_free   = !alert.valid || alert.ready;

  // rate update datapath
  logic signed [16:0] diff;
  logic [16:0]        dmag;
  logic [31:0]        dt;
  logic               div_start, div_done;
  logic [16:0]        quo;
  logic [15:0]        sat;

  assign diff = 17'(it_temp) - 17'(s_temp[curi]);
  assign dmag = diff[16] ? 17'(17'd0 - diff) : diff;
  assign dt   = it_now - s_upd[curi];
  assign div_start = (state == S_RD_UPD) && s_seen[curi] && (dt != 32'd0);

  always_comb begin
    if (!neg) sat = (quo > 17'd32767) ? 16'h7FFF : quo[15:0];
    else      sat = (quo > 17'd32768) ? 16'h8000 : 16'(17'd0 - quo);
  end

  stam_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dmag), .divisor(dt),
    .done(div_done), .quotient(quo)
  );

  // alert candidates
  logic [16:0] rmag;
  logic        cand;
  logic [2:0]  cand_code;
  logic        offline;

  assign rmag = s_rate[curi][15] ? 17'(17'd0 - 17'(s_rate[curi])) : 17'(s_rate[curi]);
  assign offline = s_active[curi] && ((it_now - s_upd[curi]) > 32'(timeout));

  always_comb begin
    cand      = 1'b0;
    cand_code = stam_pkg::CODE_TEMP_LOW;
    if (it_func) begin
      cand      = offline;
      cand_code = stam_pkg::CODE_OFFLINE;
    end else begin
      case (step)
        2'd0: begin
          if (s_temp[curi] < temp_low) begin
            cand = 1'b1;
            cand_code = stam_pkg::CODE_TEMP_LOW;
          end else if (s_temp[curi] > temp_high) begin
            cand = 1'b1;
            cand_code = stam_pkg::CODE_TEMP_HIGH;
          end
        end
        2'd1: begin
          cand      = s_hum[curi] > hum_high;
          cand_code = stam_pkg::CODE_HUM_HIGH;
        end
        2'd2: begin
          cand      = rmag > {2'b00, rate_limit};
          cand_code = s_rate[curi][15] ? stam_pkg::CODE_FALLING : stam_pkg::CODE_RISING;
        end
        default: ;
      endcase
    end
  end

  logic scan_end;
  assign scan_end = it_func ? ((cur == SCW'(NUM_SENSORS)) ||
                               (cnt == NW'(stam_pkg::MAX_RESULTS)))
                            : (step == 2'd3);

  // throttle store
  stam_pkg::thr_req_t thr_req;
  logic [TW-1:0]      slot;
  logic               thr_valid;
  logic [31:0]        thr_minute;
  logic               suppress, emit_go;
  logic               out_load;

  assign slot = TW'(TW'(curi) * TW'(stam_pkg::NUM_CODES) +
                    TW'(it_func ? stam_pkg::CODE_OFFLINE : (state == S_PICK ? cand_code : code)));
  assign suppress = thr_valid && ((it_now - thr_minute) < 32'(window));
  assign emit_go  = (state == S_TEST) && !suppress && (!pend_valid || out_free);
  assign thr_req.rd = (state == S_PICK) && !scan_end && cand;
  assign thr_req.wr = emit_go;
  // held word moves to the output register this cycle
  assign out_load = pend_valid && (emit_go || ((state == S_FIN) && out_free));

  stam_throttle #(.DEPTH(TD)) u_thr (
    .clk(clk), .rst(rst), .req(thr_req), .addr(slot), .wr_minute(it_now),
    .rd_valid(thr_valid), .rd_minute(thr_minute)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pend_valid  <= 1'b0;
      alert.valid <= 1'b0;
      s_seen      <= '0;
      s_active    <= '0;
      cur         <= '0;
      step        <= '0;
      cnt         <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        s_temp[i] <= '0;
        s_hum[i]  <= '0;
        s_rate[i] <= '0;
        s_upd[i]  <= '0;
      end
    end else begin
      if (alert.valid && alert.ready && !out_load) alert.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_acc) begin
            it_func <= item.func;
            it_temp <= item.temperature;
            it_hum  <= item.humidity;
            it_now  <= item.now_minute;
            cur     <= item.func ? '0 : SCW'(item.sensor_index);
            step    <= '0;
            cnt     <= '0;
            if (item.func) state <= S_PICK;
            else           state <= in_range ? S_RD_UPD : S_FIN;
          end
        end
        S_RD_UPD: begin
          s_temp[curi]   <= it_temp;
          s_hum[curi]    <= it_hum;
          s_upd[curi]    <= it_now;
          s_seen[curi]   <= 1'b1;
          s_active[curi] <= 1'b1;
          neg            <= diff[16];
          state          <= div_start ? S_DIV : S_PICK;
        end
        S_DIV: begin
          if (div_done) begin
            s_rate[curi] <= sat;
            state        <= S_PICK;
          end
        end
        S_PICK: begin
          if (scan_end) begin
            state <= S_FIN;
          end else if (cand) begin
            code  <= cand_code;
            state <= S_TEST;
            if (it_func) s_active[curi] <= 1'b0;
          end else if (it_func) begin
            cur <= cur + 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_TEST: begin
          if (suppress || emit_go) begin
            if (emit_go) begin
              if (pend_valid) begin
                alert.valid             <= 1'b1;
                alert.alert_sensor      <= pend.sensor;
                alert.alert_code        <= pend.code;
                alert.alert_temperature <= pend.temperature;
                alert.alert_humidity    <= pend.humidity;
                alert.alert_rate        <= pend.rate;
                alert.last_alert        <= 1'b0;
              end
              pend_valid       <= 1'b1;
              pend.sensor      <= 4'(curi);
              pend.code        <= code;
              pend.temperature <= s_temp[curi];
              pend.humidity    <= s_hum[curi];
              pend.rate        <= s_rate[curi];
              cnt              <= cnt + 1'b1;
            end
            if (it_func) cur  <= cur + 1'b1;
            else         step <= step + 1'b1;
            state <= S_PICK;
          end
        end
        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            alert.valid             <= 1'b1;
            alert.alert_sensor      <= pend.sensor;
            alert.alert_code        <= pend.code;
            alert.alert_temperature <= pend.temperature;
            alert.alert_humidity    <= pend.humidity;
            alert.alert_rate        <= pend.rate;
            alert.last_alert        <= 1'b1;
            pend_valid              <= 1'b0;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider result only lands while waiting for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider done outside wait");
  // no held result survives into idle
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid) else $error("pending alert left behind");
  // result count stays within the per-item limit
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= NW'(stam_pkg::MAX_RESULTS)) else $error("result count overflow");
  // an accepted item leaves idle on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_acc |=> state != S_IDLE) else $error("item accepted without work");
endmodule
`default_nettype wire
